// File: sv/bfd_pkg.sv
// shared types and constants for the box filter downscaler
// no dependencies; used by the front, back and top modules and the testbench
package bfd_pkg;

  // default sizing of the line store and accumulators
  localparam int DEF_MAX_LINE = 4096;
  localparam int DEF_SUM_BITS = 32;

  // row geometry is fixed by the register widths
  localparam int ROW_LIMIT = 4096;
  localparam int RW        = 13;
  localparam int TR_W      = 12;
  localparam int COORD_W   = 12;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] RST_SRC_W = 13'd640;
  localparam logic [CFG_W-1:0] RST_SRC_H = 13'd480;
  localparam logic [CFG_W-1:0] RST_TGT_W = 13'd320;
  localparam logic [CFG_W-1:0] RST_TGT_H = 13'd240;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic [7:0]         alpha_out;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    logic               frame_done;
  } pixel_out_t;

endpackage

// File: sv/bfd_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module bfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bfd_fifo.sv
// short queue of finished box sums between the front and the back
// no dependencies
module bfd_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign full     = (fill == NW'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: sv/bfd_front.sv
// front end: config registers, raster position tracking, column accumulators
// depends on bfd_pkg and bfd_ram
module bfd_front #(
  parameter int MAX_LINE = bfd_pkg::DEF_MAX_LINE,
  parameter int SUM_BITS = bfd_pkg::DEF_SUM_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bfd_pkg::pixel_in_t                  in_data,
  input  logic                                cfg_we,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]           cfg_data,
  output logic                                q_push,
  output logic [4*SUM_BITS + $clog2(MAX_LINE+1) + bfd_pkg::RW
                + $clog2(MAX_LINE) + bfd_pkg::TR_W : 0] q_data,
  input  logic                                q_full
);

  localparam int CW   = $clog2(MAX_LINE + 1);
  localparam int AW   = $clog2(MAX_LINE);
  localparam int RW   = bfd_pkg::RW;
  localparam int TRW  = bfd_pkg::TR_W;
  localparam int DW   = (CW > RW) ? CW : RW;
  localparam int SW_W = $clog2(DW);
  localparam int CNTW = CW + RW;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_IDLE = 2'd2;
  localparam logic [1:0] ST_ACC  = 2'd3;

  // configuration registers
  logic [bfd_pkg::CFG_W-1:0] src_w, src_h, tgt_w, tgt_h;
  logic                      alpha_en;
  logic                      cfg_hit;

  // effective sizes
  logic [CW-1:0] eff_sw, eff_dw;
  logic [RW-1:0] eff_sh, eff_dh;

  // control
  logic [1:0]      state, state_next;
  logic [SW_W-1:0] step;

  // setup divider
  logic [DW-1:0] dnc, dnr;
  logic [DW-1:0] drc, drr;
  logic [DW:0]   trial_c, trial_r;
  logic          ge_c, ge_r;

  // per-frame step sizes
  logic [CW-1:0] q0c, r0c;
  logic [RW-1:0] q0r, r0r;

  // raster position
  logic [CW-1:0]  src_col, cstart, cend, crem;
  logic [AW-1:0]  tc;
  logic [RW-1:0]  src_row, rstart, rend, rrem;
  logic [TRW-1:0] tr;

  logic [CW-1:0]  src_col_next, cstart_next, cend_next, crem_next;
  logic [AW-1:0]  tc_next;
  logic [RW-1:0]  src_row_next, rstart_next, rend_next, rrem_next;
  logic [TRW-1:0] tr_next;

  // datapath
  bfd_pkg::pixel_in_t      pix;
  logic [4*SUM_BITS-1:0]   rd_data, wr_data;
  logic [SUM_BITS-1:0]     sum_r, sum_g, sum_b, sum_a;
  logic [7:0]              alpha_val;
  logic                    first, emit, done;
  logic [CNTW-1:0]         count;
  logic [CW:0]             col_inc, cs;
  logic [RW:0]             row_inc, rs;
  logic [CW-1:0]           cend_adv, crem_adv;
  logic [RW-1:0]           rend_adv, rrem_adv;

  assign cfg_hit = cfg_we && (cfg_index <= bfd_pkg::CFG_ALPHA);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w    <= bfd_pkg::RST_SRC_W;
      src_h    <= bfd_pkg::RST_SRC_H;
      tgt_w    <= bfd_pkg::RST_TGT_W;
      tgt_h    <= bfd_pkg::RST_TGT_H;
      alpha_en <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfd_pkg::CFG_SRC_W: src_w    <= cfg_data;
        bfd_pkg::CFG_SRC_H: src_h    <= cfg_data;
        bfd_pkg::CFG_TGT_W: tgt_w    <= cfg_data;
        bfd_pkg::CFG_TGT_H: tgt_h    <= cfg_data;
        bfd_pkg::CFG_ALPHA: alpha_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp sizes: zero counts as one, sources are capped at MAX_LINE and ROW_LIMIT, targets never exceed sources
  always_comb begin
    if (src_w == '0) begin
      eff_sw = CW'(1);
    end else if (32'(src_w) > MAX_LINE) begin
      eff_sw = CW'(MAX_LINE);
    end else begin
      eff_sw = CW'(src_w);
    end
    if (src_h == '0) begin
      eff_sh = RW'(1);
    end else if (32'(src_h) > bfd_pkg::ROW_LIMIT) begin
      eff_sh = RW'(bfd_pkg::ROW_LIMIT);
    end else begin
      eff_sh = RW'(src_h);
    end
    if (tgt_w == '0) begin
      eff_dw = CW'(1);
    end else if (32'(tgt_w) > 32'(eff_sw)) begin
      eff_dw = eff_sw;
    end else begin
      eff_dw = CW'(tgt_w);
    end
    if (tgt_h == '0) begin
      eff_dh = RW'(1);
    end else if (tgt_h > eff_sh) begin
      eff_dh = eff_sh;
    end else begin
      eff_dh = tgt_h;
    end
  end

  // restoring divider steps for source/target quotient and remainder
  assign trial_c = {drc, dnc[DW-1]};
  assign trial_r = {drr, dnr[DW-1]};
  assign ge_c    = (trial_c >= (DW+1)'(eff_dw));
  assign ge_r    = (trial_r >= (DW+1)'(eff_dh));

  // accumulator line store
  bfd_ram #(
    .WIDTH (4*SUM_BITS),
    .DEPTH (MAX_LINE)
  ) u_sums (
    .clk   (clk),
    .we    (state == ST_ACC),
    .waddr (tc),
    .wdata (wr_data),
    .raddr (tc),
    .rdata (rd_data)
  );

  // accumulate the held pixel into its column
  always_comb begin
    first     = (src_col == cstart) && (src_row == rstart);
    alpha_val = alpha_en ? pix.alpha_in : 8'd0;
    sum_r = (first ? '0 : rd_data[0*SUM_BITS +: SUM_BITS]) + SUM_BITS'(pix.red_in);
    sum_g = (first ? '0 : rd_data[1*SUM_BITS +: SUM_BITS]) + SUM_BITS'(pix.green_in);
    sum_b = (first ? '0 : rd_data[2*SUM_BITS +: SUM_BITS]) + SUM_BITS'(pix.blue_in);
    sum_a = (first ? '0 : rd_data[3*SUM_BITS +: SUM_BITS]) + SUM_BITS'(alpha_val);
    wr_data = {sum_a, sum_b, sum_g, sum_r};
    emit  = (({1'b0, src_col} + 1'b1) == {1'b0, cend})
         && (({1'b0, src_row} + 1'b1) == {1'b0, rend});
    count = CNTW'(cend - cstart) * CNTW'(rend - rstart);
    done  = (((CW+1)'(tc) + 1'b1) == (CW+1)'(eff_dw))
         && (((RW+1)'(tr) + 1'b1) == (RW+1)'(eff_dh));
  end

  assign q_push = (state == ST_ACC) && emit;
  assign q_data = {done, tr, tc, count, sum_a, sum_b, sum_g, sum_r};
  assign in_ready = (state == ST_IDLE) && !q_full;

  // next box boundaries by running remainder
  always_comb begin
    cs = {1'b0, crem} + {1'b0, r0c};
    if (cs >= {1'b0, eff_dw}) begin
      cend_adv = cend + q0c + 1'b1;
      crem_adv = CW'(cs - {1'b0, eff_dw});
    end else begin
      cend_adv = cend + q0c;
      crem_adv = CW'(cs);
    end
    rs = {1'b0, rrem} + {1'b0, r0r};
    if (rs >= {1'b0, eff_dh}) begin
      rend_adv = rend + q0r + 1'b1;
      rrem_adv = RW'(rs - {1'b0, eff_dh});
    end else begin
      rend_adv = rend + q0r;
      rrem_adv = RW'(rs);
    end
  end

  // raster position update after each pixel and when setup finishes
  always_comb begin
    src_col_next = src_col;
    cstart_next  = cstart;
    cend_next    = cend;
    crem_next    = crem;
    tc_next      = tc;
    src_row_next = src_row;
    rstart_next  = rstart;
    rend_next    = rend;
    rrem_next    = rrem;
    tr_next      = tr;
    col_inc      = {1'b0, src_col} + 1'b1;
    row_inc      = {1'b0, src_row} + 1'b1;
    if (state == ST_DIV && step == SW_W'(DW - 1)) begin
      // setup finished next edge: restart frame from last step's values
      src_col_next = '0;
      cstart_next  = '0;
      cend_next    = CW'({dnc[DW-2:0], ge_c});
      crem_next    = CW'(ge_c ? trial_c - (DW+1)'(eff_dw) : trial_c);
      tc_next      = '0;
      src_row_next = '0;
      rstart_next  = '0;
      rend_next    = RW'({dnr[DW-2:0], ge_r});
      rrem_next    = RW'(ge_r ? trial_r - (DW+1)'(eff_dh) : trial_r);
      tr_next      = '0;
    end else if (state == ST_ACC) begin
      if (col_inc >= {1'b0, eff_sw}) begin
        src_col_next = '0;
        tc_next      = '0;
        cstart_next  = '0;
        cend_next    = q0c;
        crem_next    = r0c;
        if (row_inc >= {1'b0, eff_sh}) begin
          src_row_next = '0;
          tr_next      = '0;
          rstart_next  = '0;
          rend_next    = q0r;
          rrem_next    = r0r;
        end else begin
          src_row_next = RW'(row_inc);
          if (row_inc >= {1'b0, rend}) begin
            tr_next     = tr + 1'b1;
            rstart_next = rend;
            rend_next   = rend_adv;
            rrem_next   = rrem_adv;
          end
        end
      end else begin
        src_col_next = CW'(col_inc);
        if (col_inc >= {1'b0, cend}) begin
          tc_next     = tc + 1'b1;
          cstart_next = cend;
          cend_next   = cend_adv;
          crem_next   = crem_adv;
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (step == SW_W'(DW - 1)) state_next = ST_IDLE;
      ST_IDLE: if (in_valid && in_ready) state_next = ST_ACC;
      ST_ACC:  state_next = ST_IDLE;
      default: state_next = ST_LOAD;
    endcase
    if (cfg_hit) begin
      state_next = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      step    <= '0;
      src_col <= '0;
      cstart  <= '0;
      cend    <= '0;
      crem    <= '0;
      tc      <= '0;
      src_row <= '0;
      rstart  <= '0;
      rend    <= '0;
      rrem    <= '0;
      tr      <= '0;
    end else begin
      state   <= state_next;
      step    <= (state == ST_DIV) ? step + 1'b1 : '0;
      src_col <= src_col_next;
      cstart  <= cstart_next;
      cend    <= cend_next;
      crem    <= crem_next;
      tc      <= tc_next;
      src_row <= src_row_next;
      rstart  <= rstart_next;
      rend    <= rend_next;
      rrem    <= rrem_next;
      tr      <= tr_next;
    end
  end

  // divider datapath and held pixel
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      dnc <= DW'(eff_sw);
      dnr <= DW'(eff_sh);
      drc <= '0;
      drr <= '0;
    end else if (state == ST_DIV) begin
      dnc <= {dnc[DW-2:0], ge_c};
      dnr <= {dnr[DW-2:0], ge_r};
      drc <= DW'(ge_c ? trial_c - (DW+1)'(eff_dw) : trial_c);
      drr <= DW'(ge_r ? trial_r - (DW+1)'(eff_dh) : trial_r);
    end
    if (state == ST_DIV && step == SW_W'(DW - 1)) begin
      q0c <= CW'({dnc[DW-2:0], ge_c});
      r0c <= CW'(ge_c ? trial_c - (DW+1)'(eff_dw) : trial_c);
      q0r <= RW'({dnr[DW-2:0], ge_r});
      r0r <= RW'(ge_r ? trial_r - (DW+1)'(eff_dh) : trial_r);
    end
    if (in_valid && in_ready) begin
      pix <= in_data;
    end
  end

endmodule

// File: sv/bfd_back.sv
// back end: divides box sums by the pixel count and holds the result item
// depends on bfd_pkg
module bfd_back #(
  parameter int MAX_LINE = bfd_pkg::DEF_MAX_LINE,
  parameter int SUM_BITS = bfd_pkg::DEF_SUM_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 q_pop,
  input  logic [4*SUM_BITS + $clog2(MAX_LINE+1) + bfd_pkg::RW
                + $clog2(MAX_LINE) + bfd_pkg::TR_W : 0] q_data,
  input  logic                 q_empty,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bfd_pkg::pixel_out_t  out_data
);

  localparam int CW   = $clog2(MAX_LINE + 1);
  localparam int AW   = $clog2(MAX_LINE);
  localparam int TRW  = bfd_pkg::TR_W;
  localparam int CNTW = CW + bfd_pkg::RW;
  localparam int KW   = $clog2(SUM_BITS);
  localparam int CO   = 4*SUM_BITS;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_OUT  = 2'd2;

  logic [1:0]          state;
  logic [KW-1:0]       step;
  logic [SUM_BITS-1:0] num [4];
  logic [CNTW-1:0]     rem [4];
  logic [CNTW:0]       trial [4];
  logic [3:0]          ge;
  logic [CNTW-1:0]     divisor;
  logic [AW-1:0]       col;
  logic [TRW-1:0]      row;
  logic                done;

  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign out_valid = (state == B_OUT);

  // one quotient bit per channel per cycle
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      trial[k] = {rem[k], num[k][SUM_BITS-1]};
      ge[k]    = (trial[k] >= {1'b0, divisor});
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          step <= '0;
          if (!q_empty) state <= B_DIV;
        end
        B_DIV: begin
          step <= step + 1'b1;
          if (step == KW'(SUM_BITS - 1)) state <= B_OUT;
        end
        B_OUT: if (out_ready) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // dividend, remainder and item fields
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < 4; k++) begin
        num[k] <= q_data[k*SUM_BITS +: SUM_BITS];
        rem[k] <= '0;
      end
      divisor <= (q_data[CO +: CNTW] == '0) ? CNTW'(1) : q_data[CO +: CNTW];
      col     <= q_data[CO + CNTW +: AW];
      row     <= q_data[CO + CNTW + AW +: TRW];
      done    <= q_data[CO + CNTW + AW + TRW];
    end else if (state == B_DIV) begin
      for (int k = 0; k < 4; k++) begin
        num[k] <= {num[k][SUM_BITS-2:0], ge[k]};
        rem[k] <= CNTW'(ge[k] ? trial[k] - {1'b0, divisor} : trial[k]);
      end
    end
  end

  assign out_data.red_out    = num[0][7:0];
  assign out_data.green_out  = num[1][7:0];
  assign out_data.blue_out   = num[2][7:0];
  assign out_data.alpha_out  = num[3][7:0];
  assign out_data.out_column = bfd_pkg::COORD_W'(col);
  assign out_data.out_row    = row;
  assign out_data.frame_done = done;

endmodule

// File: sv/box_filter_image_downscaler.sv
// area averaging downscaler: each source pixel is a ram read then write, and the next pixel waits for the write
// a result item passes through the queue and a bit serial divide after a box's last pixel
// back end handles one result item at a time; a 4-entry queue separates the two
// after reset or a write to one of the five registers, in_ready stays low during size setup
// reset is synchronous; accumulators are not cleared, each box's first pixel overwrites
module box_filter_image_downscaler #(
  parameter int MAX_LINE = bfd_pkg::DEF_MAX_LINE,
  parameter int SUM_BITS = bfd_pkg::DEF_SUM_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bfd_pkg::pixel_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bfd_pkg::pixel_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int QW = 4*SUM_BITS + $clog2(MAX_LINE + 1) + bfd_pkg::RW
                    + $clog2(MAX_LINE) + bfd_pkg::TR_W + 1;

  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_in, q_out;

  // pixel intake and accumulation
  bfd_front #(
    .MAX_LINE (MAX_LINE),
    .SUM_BITS (SUM_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  // finished boxes waiting for division
  bfd_fifo #(
    .WIDTH (QW),
    .DEPTH (bfd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // averaging and output hold
  bfd_back #(
    .MAX_LINE (MAX_LINE),
    .SUM_BITS (SUM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_pop     (q_pop),
    .q_data    (q_out),
    .q_empty   (q_empty),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("box queue overflow");

  // queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("box queue underflow");

  // a register write stops intake for setup
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index <= bfd_pkg::CFG_ALPHA) |=> !in_ready)
    else $error("item taken during size setup");

  // no item taken while queue is full
  a_ready_room: assert property (@(posedge clk) disable iff (rst) in_ready |-> !q_full)
    else $error("intake open with full queue");

endmodule

// File: sim/testbench.sv
// self-checking testbench for box_filter_image_downscaler
// depends on bfd_pkg and the block's rtl; predicts every result item internally
`timescale 1ns / 100ps

module testbench;

  localparam int LINE_MAX   = 4096;
  localparam int DRAIN_WAIT = 100;
  localparam int CYCLE_CAP  = 3000000;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  bfd_pkg::pixel_in_t            in_data;
  logic                          out_valid;
  logic                          out_ready;
  bfd_pkg::pixel_out_t           out_data;
  logic                          cfg_we;
  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bfd_pkg::CFG_W-1:0]     cfg_data;

  box_filter_image_downscaler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // scaler model state
  int unsigned src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg, alpha_on;
  logic [31:0] red_acc [LINE_MAX];
  logic [31:0] grn_acc [LINE_MAX];
  logic [31:0] blu_acc [LINE_MAX];
  logic [31:0] alp_acc [LINE_MAX];
  int unsigned src_col, src_row, tgt_col, tgt_row;
  int unsigned col_end, row_start, row_end;

  bfd_pkg::pixel_out_t pending_pixels[$];
  int          fail_count;
  int          cycle_count;
  int          rx_hold;
  bit          rx_no_idle;
  bit          tx_no_idle;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_src_w();
    return clamp_dim(src_w_reg, LINE_MAX);
  endfunction
  function automatic int unsigned eff_src_h();
    return clamp_dim(src_h_reg, bfd_pkg::ROW_LIMIT);
  endfunction
  function automatic int unsigned eff_tgt_w();
    return clamp_dim(tgt_w_reg, eff_src_w());
  endfunction
  function automatic int unsigned eff_tgt_h();
    return clamp_dim(tgt_h_reg, eff_src_h());
  endfunction

  function automatic int unsigned split_at(int unsigned size, int unsigned k,
                                           int unsigned parts);
    longint unsigned prod;
    prod = longint'(size) * k;
    return int'(prod / parts);
  endfunction

  function automatic void restart_scan();
    src_col   = 0;
    src_row   = 0;
    tgt_col   = 0;
    tgt_row   = 0;
    row_start = 0;
    col_end   = split_at(eff_src_w(), 1, eff_tgt_w());
    row_end   = split_at(eff_src_h(), 1, eff_tgt_h());
  endfunction

  // accumulate one source pixel, queue the averaged pixel when a box closes
  function automatic void scale_pixel(bfd_pkg::pixel_in_t p);
    int unsigned sw, sh, dw, dh, tc, cstart;
    longint unsigned cnt;
    bit first;
    bfd_pkg::pixel_out_t r;
    sw = eff_src_w();
    sh = eff_src_h();
    dw = eff_tgt_w();
    dh = eff_tgt_h();
    tc = (tgt_col >= LINE_MAX) ? LINE_MAX - 1 : tgt_col;
    cstart = split_at(sw, tc, dw);
    first = (src_col == cstart) && (src_row == row_start);
    red_acc[tc] = (first ? 32'd0 : red_acc[tc]) + p.red_in;
    grn_acc[tc] = (first ? 32'd0 : grn_acc[tc]) + p.green_in;
    blu_acc[tc] = (first ? 32'd0 : blu_acc[tc]) + p.blue_in;
    alp_acc[tc] = (first ? 32'd0 : alp_acc[tc]) + (alpha_on ? p.alpha_in : 8'd0);
    if (src_col + 1 == col_end && src_row + 1 == row_end) begin
      cnt = longint'(col_end - cstart) * (row_end - row_start);
      if (cnt == 0) cnt = 1;
      r.red_out    = 8'(red_acc[tc] / cnt);
      r.green_out  = 8'(grn_acc[tc] / cnt);
      r.blue_out   = 8'(blu_acc[tc] / cnt);
      r.alpha_out  = alpha_on ? 8'(alp_acc[tc] / cnt) : 8'd0;
      r.out_column = bfd_pkg::COORD_W'(tc);
      r.out_row    = bfd_pkg::COORD_W'(tgt_row);
      r.frame_done = (tc + 1 == dw) && (tgt_row + 1 == dh);
      pending_pixels.push_back(r);
    end
    src_col++;
    if (src_col >= sw) begin
      src_col = 0;
      tgt_col = 0;
      col_end = split_at(sw, 1, dw);
      src_row++;
      if (src_row >= sh) begin
        restart_scan();
      end else if (src_row >= row_end) begin
        tgt_row++;
        row_start = row_end;
        row_end = split_at(sh, tgt_row + 1, dh);
      end
    end else if (src_col >= col_end) begin
      tgt_col++;
      col_end = split_at(sw, tgt_col + 1, dw);
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("box_filter_image_downscaler: mismatch");
      $finish;
    end
  end

  // long receiver hold-off, counted down on its own
  always @(posedge clk) begin
    if (rx_hold > 0) rx_hold <= rx_hold - 1;
  end

  // receiver: random stalls, result item check
  int rx_wait;
  initial rx_wait = 0;
  always @(posedge clk) begin
    bfd_pkg::pixel_out_t exp_px;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_data);
        fail_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (exp_px.red_out !== out_data.red_out)
          $display("%0t: red exp %0d got %0d", $time, exp_px.red_out, out_data.red_out);
        if (exp_px.green_out !== out_data.green_out)
          $display("%0t: green exp %0d got %0d", $time, exp_px.green_out,
                   out_data.green_out);
        if (exp_px.blue_out !== out_data.blue_out)
          $display("%0t: blue exp %0d got %0d", $time, exp_px.blue_out, out_data.blue_out);
        if (exp_px.alpha_out !== out_data.alpha_out)
          $display("%0t: alpha exp %0d got %0d", $time, exp_px.alpha_out,
                   out_data.alpha_out);
        if (exp_px.out_column !== out_data.out_column)
          $display("%0t: column exp %0d got %0d", $time, exp_px.out_column,
                   out_data.out_column);
        if (exp_px.out_row !== out_data.out_row)
          $display("%0t: row exp %0d got %0d", $time, exp_px.out_row, out_data.out_row);
        if (exp_px.frame_done !== out_data.frame_done)
          $display("%0t: frame_done exp %0d got %0d", $time, exp_px.frame_done,
                   out_data.frame_done);
        if (exp_px !== out_data) fail_count++;
      end
      rx_wait = rx_no_idle ? 0 : $urandom_range(0, 18);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_ready <= (rx_hold <= 1) && (rx_wait == 0);
  end

  // send one source pixel item, keeping valid high across back-to-back items
  task automatic send_pixel(bfd_pkg::pixel_in_t p);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scale_pixel(p);
  endtask

  function automatic bfd_pkg::pixel_in_t rand_pixel();
    bfd_pkg::pixel_in_t p;
    p = $urandom;
    case ($urandom_range(0, 7))
      0: p = '0;
      1: p = '1;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixels(int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // let the block go idle before touching a register
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [bfd_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bfd_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      bfd_pkg::CFG_SRC_W: src_w_reg = val & 13'h1fff;
      bfd_pkg::CFG_SRC_H: src_h_reg = val & 13'h1fff;
      bfd_pkg::CFG_TGT_W: tgt_w_reg = val & 13'h1fff;
      bfd_pkg::CFG_TGT_H: tgt_h_reg = val & 13'h1fff;
      bfd_pkg::CFG_ALPHA: alpha_on  = val & 1;
      default: ;
    endcase
    restart_scan();
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned dw,
                              int unsigned dh, int unsigned al);
    write_reg(bfd_pkg::CFG_SRC_W, sw);
    write_reg(bfd_pkg::CFG_SRC_H, sh);
    write_reg(bfd_pkg::CFG_TGT_W, dw);
    write_reg(bfd_pkg::CFG_TGT_H, dh);
    write_reg(bfd_pkg::CFG_ALPHA, al);
  endtask

  // reset sizes: 640x480 down to 320x240, up to the first closed box
  task automatic test_reset_sizes();
    send_pixels(640 + 2);
  endtask

  // single pixel frames at both value extremes, zero sizes count as one
  task automatic test_extremes();
    set_geometry(1, 1, 1, 1, 1);
    send_pixel('0);
    send_pixel('1);
    set_geometry(0, 0, 0, 0, 0);
    send_pixel('1);
    send_pixel('0);
    send_pixel(rand_pixel());
  endtask

  // target larger than source is clamped, uneven boxes
  task automatic test_upscale_clamp();
    set_geometry(5, 3, 9, 7, 1);
    send_pixels(17);
    set_geometry(7, 5, 3, 2, 1);
    send_pixels(36);
  endtask

  // oversized width saturates, every pixel its own box
  task automatic test_wide_line();
    set_geometry(8191, 1, 8191, 1, 0);
    tx_no_idle = 1;
    rx_no_idle = 1;
    send_pixels(40);
    tx_no_idle = 0;
    rx_no_idle = 0;
  endtask

  // oversized height saturates, tall boxes of full-scale pixels
  task automatic test_tall_box();
    set_geometry(2, 8191, 1, 64, 1);
    tx_no_idle = 1;
    repeat (256) send_pixel('1);
    tx_no_idle = 0;
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    set_geometry(8, 4, 8, 4, 1);
    tx_no_idle = 1;
    rx_hold = 600;
    send_pixels(64);
    tx_no_idle = 0;
  endtask

  // random geometries, mostly whole frames, some cut short
  task automatic test_random();
    int sent;
    int unsigned sw, sh, frame, part;
    sent = 0;
    while (sent < 300) begin
      sw = $urandom_range(1, 20);
      sh = $urandom_range(1, 10);
      set_geometry($urandom_range(0, 7) == 0 ? 0 : sw, sh,
                   $urandom_range(0, sw + 3), $urandom_range(0, sh + 3),
                   $urandom_range(0, 1));
      frame = eff_src_w() * eff_src_h();
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, frame);
        send_pixels(part);
        sent += part;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_pixels(frame);
          sent += frame;
        end
      end
    end
    tx_no_idle = 0;
    rx_no_idle = 0;
  endtask

  // test sequence
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = bfd_pkg::CFG_SRC_W;
    cfg_data   = '0;
    fail_count = 0;
    rx_hold    = 0;
    rx_no_idle = 0;
    tx_no_idle = 0;
    src_w_reg  = bfd_pkg::RST_SRC_W;
    src_h_reg  = bfd_pkg::RST_SRC_H;
    tgt_w_reg  = bfd_pkg::RST_TGT_W;
    tgt_h_reg  = bfd_pkg::RST_TGT_H;
    alpha_on   = 0;
    restart_scan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_sizes();
    test_extremes();
    test_upscale_clamp();
    test_backpressure();
    test_wide_line();
    test_tall_box();
    test_random();

    wait_idle();
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d items never arrived", $time, pending_pixels.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("box_filter_image_downscaler: match");
    end else begin
      $display("box_filter_image_downscaler: mismatch");
    end
    $finish;
  end

endmodule
